@@ src/vpps_pkg.sv @@
// Shared types, constants and helpers for the voice pool with priority stealing.
// No dependencies; imported by every module of the block.
`default_nettype none

package vpps_pkg;

    // Pool geometry
    localparam int VOICE_COUNT = 32;
    localparam int IDX_W       = $clog2(VOICE_COUNT);
    localparam int SLOT_W      = 5;
    localparam int PRIO_W      = 2;
    localparam int TICK_W      = 32;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FINISHED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP_ALL = 3'd4;

    // Grant status codes
    localparam logic [STATUS_W-1:0] STAT_FREE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STOLEN  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd3;

    // Stored priority of a granted voice
    localparam logic [PRIO_W-1:0] PRIO_LOOP = 2'd2;
    localparam logic [PRIO_W-1:0] PRIO_ONCE = 2'd1;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Request and result payloads
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PRIO_W-1:0] request_priority;
        logic              loop_flag;
        logic [SLOT_W-1:0] voice_slot;
    } vpps_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic [STATUS_W-1:0] grant_status;
    } vpps_rsp_t;

    // One entry offered to the victim compare unit
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  index;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] tick;
        logic [PRIO_W-1:0] req;
    } vpps_step_t;

    // Best victim so far, including the entry offered this cycle
    typedef struct packed {
        logic             have;
        logic [IDX_W-1:0] pick;
    } vpps_best_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } vpps_hit_t;

    // Lowest set bit of a pool-wide mask
    function automatic vpps_hit_t first_set(input logic [VOICE_COUNT-1:0] v);
        vpps_hit_t h;
        h.found = 1'b0;
        h.idx   = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                h.found = 1'b1;
                h.idx   = IDX_W'(i);
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

@@ src/voice_pool_priority_stealing_top.sv @@
// Voice pool top level: voice state, sequencer and result register.
// Depends on vpps_pkg and vpps_victim_scan.
// Release, finished, tick, stop-all and an acquire that finds a free or
//   finished slot give their result in the cycle after the request is taken.
// An acquire that must steal walks all VOICE_COUNT voices through one compare
//   unit, one voice a cycle, and gives its result when the walk ends.
// busy is low again in the cycle the result strobe shows; results cannot stall.
// Reset clears every voice mark, priority, start tick and the tick counter.
`default_nettype none

module voice_pool_priority_stealing_top
    import vpps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire vpps_req_t request,
    output logic           done,
    output vpps_rsp_t      result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [PRIO_W-1:0]      req_prio_reg;
    logic                   loop_reg;
    logic [VOICE_COUNT-1:0] active_reg, active_next;
    logic [VOICE_COUNT-1:0] owned_reg, owned_next;
    logic [VOICE_COUNT-1:0] playing_reg, playing_next;
    logic [PRIO_W-1:0]      prio_reg [VOICE_COUNT];
    logic [TICK_W-1:0]      start_tick_reg [VOICE_COUNT];
    logic [TICK_W-1:0]      tick_count_reg, tick_count_next;
    logic                   done_reg, done_next;
    vpps_rsp_t              result_reg, result_next;

    logic             accept;
    logic             slot_ok;
    vpps_hit_t        free_hit, fin_hit;
    vpps_step_t       step;
    vpps_best_t       best;
    logic             grant_en;
    logic [IDX_W-1:0] grant_idx;
    logic             grant_loop;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = (32'(request.voice_slot) < 32'(VOICE_COUNT));

    // Slot searches for the first two acquire passes
    assign free_hit = first_set(~active_reg);
    assign fin_hit  = first_set(active_reg & ~playing_reg);

    // Steal pass: offer one voice a cycle to the compare unit
    assign step.valid = (state_reg == ST_SCAN);
    assign step.index = idx_reg;
    assign step.prio  = prio_reg[idx_reg];
    assign step.tick  = start_tick_reg[idx_reg];
    assign step.req   = req_prio_reg;

    vpps_victim_scan u_victim_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .step  (step),
        .best  (best)
    );

    // Sequencer and voice mark updates
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        owned_next      = owned_reg;
        playing_next    = playing_reg;
        tick_count_next = tick_count_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        grant_en        = 1'b0;
        grant_idx       = '0;
        grant_loop      = loop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next                = 1'b1;
                    result_next.granted_slot = '0;
                    result_next.grant_status = STAT_FREE;
                    grant_loop               = request.loop_flag;
                    case (request.mode)
                        MODE_ACQUIRE:
                        begin
                            if (free_hit.found)
                            begin
                                grant_en  = 1'b1;
                                grant_idx = free_hit.idx;
                                result_next.granted_slot = SLOT_W'(free_hit.idx);
                            end
                            else if (fin_hit.found)
                            begin
                                grant_en  = 1'b1;
                                grant_idx = fin_hit.idx;
                                result_next.granted_slot = SLOT_W'(fin_hit.idx);
                                result_next.grant_status = STAT_REUSED;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_SCAN;
                                idx_next   = '0;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            for (int i = 0; i < VOICE_COUNT; i++)
                            begin
                                if (slot_ok && (32'(request.voice_slot) == 32'(i)))
                                begin
                                    owned_next[i] = 1'b0;
                                end
                            end
                        end
                        MODE_FINISHED:
                        begin
                            for (int i = 0; i < VOICE_COUNT; i++)
                            begin
                                if (slot_ok && (32'(request.voice_slot) == 32'(i)))
                                begin
                                    playing_next[i] = 1'b0;
                                end
                            end
                        end
                        MODE_TICK:
                        begin
                            if (tick_count_reg != TICK_MAX)
                            begin
                                tick_count_next = tick_count_reg + 1'b1;
                            end
                            // recycle finished voices nobody owns
                            active_next = active_reg & (owned_reg | playing_reg);
                            owned_next  = owned_reg & (owned_reg | playing_reg);
                        end
                        MODE_STOP_ALL:
                        begin
                            active_next  = '0;
                            owned_next   = '0;
                            playing_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (32'(idx_reg) == 32'(VOICE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (best.have)
                    begin
                        grant_en  = 1'b1;
                        grant_idx = best.pick;
                        result_next.granted_slot = SLOT_W'(best.pick);
                        result_next.grant_status = STAT_STOLEN;
                    end
                    else
                    begin
                        result_next.granted_slot = '0;
                        result_next.grant_status = STAT_REFUSED;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A granted voice starts active, owned and playing
        if (grant_en)
        begin
            active_next[grant_idx]  = 1'b1;
            owned_next[grant_idx]   = 1'b1;
            playing_next[grant_idx] = 1'b1;
        end
    end

    // Control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            owned_reg      <= '0;
            playing_reg    <= '0;
            tick_count_reg <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                prio_reg[i]       <= '0;
                start_tick_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            owned_reg      <= owned_next;
            playing_reg    <= playing_next;
            tick_count_reg <= tick_count_next;
            done_reg       <= done_next;
            if (grant_en)
            begin
                prio_reg[grant_idx]       <= grant_loop ? PRIO_LOOP : PRIO_ONCE;
                start_tick_reg[grant_idx] <= tick_count_reg;
            end
        end
    end

    // Request fields held for the steal pass, and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_prio_reg <= request.request_priority;
            loop_reg     <= request.loop_flag;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A refused acquire reports slot zero
    a_refused_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.grant_status == STAT_REFUSED)) |-> (result.granted_slot == '0))
        else $error("refused acquire with nonzero slot");

    // A steal or refusal only ends a full scan
    a_steal_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((result.grant_status == STAT_STOLEN) ||
                  (result.grant_status == STAT_REFUSED)))
        |-> $past(state_reg == ST_SCAN))
        else $error("steal result without a scan");

    // Any request other than a scanning acquire answers on the next cycle
    a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (state_next == ST_IDLE)) |=> done)
        else $error("missing result strobe");

    // No result strobe while the scan is still running
    a_no_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !done)
        else $error("result strobe during scan");

    // Tick counter never moves backward
    a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (tick_count_reg >= $past(tick_count_reg)))
        else $error("tick counter decreased");

endmodule

`default_nettype wire

@@ src/vpps_victim_scan.sv @@
// Victim compare unit: one priority/start-tick comparison per cycle, keeps the best.
// Depends on vpps_pkg.
`default_nettype none

module vpps_victim_scan
    import vpps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       clear,
    input  wire vpps_step_t step,
    output vpps_best_t      best
);

    logic              have_reg, have_next;
    logic [PRIO_W-1:0] pri_reg, pri_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic              qualify, better;

    // Lower priority wins, then older start tick; ties keep the lower index
    always_comb
    begin
        qualify   = step.valid && (step.prio <= step.req);
        better    = !have_reg || (step.prio < pri_reg) ||
                    ((step.prio == pri_reg) && (step.tick < tick_reg));
        have_next = have_reg;
        pri_next  = pri_reg;
        tick_next = tick_reg;
        pick_next = pick_reg;
        if (clear)
        begin
            have_next = 1'b0;
        end
        else if (qualify && better)
        begin
            have_next = 1'b1;
            pri_next  = step.prio;
            tick_next = step.tick;
            pick_next = step.index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    // Comparison payload, no reset needed
    always_ff @(posedge clk)
    begin
        pri_reg  <= pri_next;
        tick_reg <= tick_next;
        pick_reg <= pick_next;
    end

    assign best.have = have_next;
    assign best.pick = pick_next;

endmodule

`default_nettype wire

@@ sim/tb_voice_pool_priority_stealing_top.sv @@
// Self-checking testbench for voice_pool_priority_stealing_top: random requests with gaps,
// an in-bench voice pool predictor, and an in-order result checker.
// Depends on vpps_pkg and the RTL under src.
`default_nettype none

module tb_voice_pool_priority_stealing_top;
    import vpps_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int MAX_GAP     = 19;

    // Request mixes used by the random segments
    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    vpps_req_t request = '0;
    logic      busy;
    logic      done;
    vpps_rsp_t result;

    // Pending requests and the idle cycles that precede each one
    vpps_req_t   req_q[$];
    int unsigned gap_q[$];
    int unsigned idle_left = 0;

    // Grants predicted for accepted requests, oldest first
    vpps_rsp_t grant_q[$];
    int        mismatch_count = 0;

    // Predicted voice pool state
    bit          pool_active [VOICE_COUNT];
    bit          pool_owned  [VOICE_COUNT];
    bit          pool_playing[VOICE_COUNT];
    bit [1:0]    pool_prio   [VOICE_COUNT];
    bit [31:0]   pool_start  [VOICE_COUNT];
    bit [31:0]   tick_now = '0;

    voice_pool_priority_stealing_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one request to the predicted pool and return the grant it gives
    function automatic vpps_rsp_t grant_for(input vpps_req_t rq);
        vpps_rsp_t rsp;
        bit        found;
        bit        have;
        int        pick;
        bit [1:0]  best_prio;
        bit [31:0] best_tick;
        rsp       = '0;
        found     = 1'b0;
        have      = 1'b0;
        pick      = 0;
        best_prio = '0;
        best_tick = '0;
        case (rq.mode)
            MODE_ACQUIRE:
            begin
                // free slot first, then a finished one, then a steal
                for (int i = 0; i < VOICE_COUNT && !found; i++)
                begin
                    if (!pool_active[i])
                    begin
                        pick = i;
                        found = 1'b1;
                        rsp.grant_status = STAT_FREE;
                    end
                end
                for (int i = 0; i < VOICE_COUNT && !found; i++)
                begin
                    if (pool_active[i] && !pool_playing[i])
                    begin
                        pick = i;
                        found = 1'b1;
                        rsp.grant_status = STAT_REUSED;
                    end
                end
                if (!found)
                begin
                    for (int i = 0; i < VOICE_COUNT; i++)
                    begin
                        if (pool_prio[i] <= rq.request_priority &&
                            (!have || pool_prio[i] < best_prio ||
                             (pool_prio[i] == best_prio && pool_start[i] < best_tick)))
                        begin
                            have = 1'b1;
                            pick = i;
                            best_prio = pool_prio[i];
                            best_tick = pool_start[i];
                        end
                    end
                    if (have)
                    begin
                        found = 1'b1;
                        rsp.grant_status = STAT_STOLEN;
                    end
                end
                if (found)
                begin
                    pool_active[pick]  = 1'b1;
                    pool_owned[pick]   = 1'b1;
                    pool_playing[pick] = 1'b1;
                    pool_prio[pick]    = rq.loop_flag ? PRIO_LOOP : PRIO_ONCE;
                    pool_start[pick]   = tick_now;
                    rsp.granted_slot   = SLOT_W'(pick);
                end
                else
                begin
                    rsp.granted_slot = '0;
                    rsp.grant_status = STAT_REFUSED;
                end
            end
            MODE_RELEASE:
            begin
                if (rq.voice_slot < VOICE_COUNT)
                    pool_owned[rq.voice_slot] = 1'b0;
            end
            MODE_FINISHED:
            begin
                if (rq.voice_slot < VOICE_COUNT)
                    pool_playing[rq.voice_slot] = 1'b0;
            end
            MODE_TICK:
            begin
                if (tick_now != TICK_MAX)
                    tick_now = tick_now + 1;
                // recycle finished voices nobody owns
                for (int i = 0; i < VOICE_COUNT; i++)
                begin
                    if (pool_active[i] && !pool_owned[i] && !pool_playing[i])
                    begin
                        pool_active[i]  = 1'b0;
                        pool_owned[i]   = 1'b0;
                        pool_playing[i] = 1'b0;
                    end
                end
            end
            MODE_STOP_ALL:
            begin
                for (int i = 0; i < VOICE_COUNT; i++)
                begin
                    pool_active[i]  = 1'b0;
                    pool_owned[i]   = 1'b0;
                    pool_playing[i] = 1'b0;
                end
            end
            default:
            begin
                // unused modes leave the pool alone
            end
        endcase
        return rsp;
    endfunction

    function automatic vpps_req_t random_request(input mix_t mix);
        vpps_req_t   rq;
        int unsigned roll;
        rq.request_priority = PRIO_W'($urandom_range(0, 3));
        rq.loop_flag        = 1'($urandom_range(0, 1));
        rq.voice_slot       = SLOT_W'($urandom_range(0, 31));
        roll                = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                rq.mode = roll < 75 ? MODE_ACQUIRE  :
                          roll < 85 ? MODE_FINISHED :
                          roll < 95 ? MODE_TICK     : MODE_RELEASE;
            MIX_CHURN:
                rq.mode = roll < 35 ? MODE_ACQUIRE  :
                          roll < 60 ? MODE_FINISHED :
                          roll < 80 ? MODE_RELEASE  :
                          roll < 94 ? MODE_TICK     :
                          roll < 96 ? MODE_STOP_ALL : MODE_W'($urandom_range(5, 7));
            default:
                rq.mode = roll < 15 ? MODE_ACQUIRE  :
                          roll < 50 ? MODE_FINISHED :
                          roll < 75 ? MODE_RELEASE  :
                          roll < 95 ? MODE_TICK     : MODE_STOP_ALL;
        endcase
        return rq;
    endfunction

    function automatic void push_request(input vpps_req_t rq, input int unsigned gap);
        req_q.push_back(rq);
        gap_q.push_back(gap);
    endfunction

    function automatic void push_directed(input logic [MODE_W-1:0] mode,
                                          input int unsigned prio, input bit loop_on,
                                          input int unsigned slot);
        vpps_req_t rq;
        rq.mode             = mode;
        rq.request_priority = PRIO_W'(prio);
        rq.loop_flag        = loop_on;
        rq.voice_slot       = SLOT_W'(slot);
        push_request(rq, $urandom_range(0, 1) ? $urandom_range(0, MAX_GAP) : 0);
    endfunction

    function automatic void report_mismatch(input string what, input vpps_rsp_t want,
                                            input vpps_rsp_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected slot %0d status %0d, got slot %0d status %0d",
                     what, want.granted_slot, want.grant_status,
                     got.granted_slot, got.grant_status);
    endfunction

    // Driver: present queued requests, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            request   <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                grant_q.push_back(grant_for(request));
            if (start && busy)
            begin
                // request still waiting to be taken
            end
            else if (idle_left != 0)
            begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end
            else if (gap_q.size() != 0 && gap_q[0] != 0)
            begin
                idle_left <= gap_q[0] - 1;
                gap_q[0] = 0;
                start     <= 1'b0;
            end
            else if (req_q.size() != 0)
            begin
                request <= req_q.pop_front();
                void'(gap_q.pop_front());
                start   <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result must match the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (grant_q.size() == 0)
                report_mismatch("no request outstanding", vpps_rsp_t'('0), result);
            else if (result.granted_slot !== grant_q[0].granted_slot)
                report_mismatch("granted_slot", grant_q.pop_front(), result);
            else if (result.grant_status !== grant_q[0].grant_status)
                report_mismatch("grant_status", grant_q.pop_front(), result);
            else
                void'(grant_q.pop_front());
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned counted;
        int unsigned seg_len;
        bit          no_gaps;
        mix_t        mix;
        vpps_req_t   rq;

        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            pool_active[i]  = 1'b0;
            pool_owned[i]   = 1'b0;
            pool_playing[i] = 1'b0;
            pool_prio[i]    = '0;
            pool_start[i]   = '0;
        end

        // directed: unused modes, free grants, idle-slot notices, tick recycling, stop-all
        push_directed(3'd5, 3, 1'b1, 31);
        push_directed(3'd6, 0, 1'b0, 0);
        push_directed(3'd7, 2, 1'b1, 21);
        push_directed(MODE_ACQUIRE, 0, 1'b0, 0);
        push_directed(MODE_ACQUIRE, 3, 1'b1, 31);
        push_directed(MODE_ACQUIRE, 1, 1'b0, 10);
        push_directed(MODE_FINISHED, 0, 1'b0, 0);
        push_directed(MODE_ACQUIRE, 2, 1'b1, 0);
        push_directed(MODE_FINISHED, 0, 1'b0, 31);
        push_directed(MODE_RELEASE, 3, 1'b1, 31);
        push_directed(MODE_RELEASE, 0, 1'b0, 1);
        push_directed(MODE_FINISHED, 0, 1'b0, 1);
        push_directed(MODE_TICK, 3, 1'b1, 7);
        push_directed(MODE_ACQUIRE, 3, 1'b0, 0);
        push_directed(MODE_TICK, 0, 1'b0, 0);
        push_directed(MODE_STOP_ALL, 3, 1'b1, 31);
        push_directed(MODE_ACQUIRE, 0, 1'b1, 0);
        push_directed(MODE_STOP_ALL, 0, 1'b0, 0);
        counted = 15;

        // random segments, each with its own request mix and gap style
        while (counted < ITEM_TARGET)
        begin
            seg_len = $urandom_range(8, 60);
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mix = MIX_FILL;
                4, 5, 6, 7: mix = MIX_CHURN;
                default:    mix = MIX_DRAIN;
            endcase
            for (int n = 0; n < seg_len; n++)
            begin
                rq = random_request(mix);
                push_request(rq, no_gaps ? 0 : $urandom_range(0, MAX_GAP));
                if (rq.mode <= MODE_STOP_ALL)
                    counted++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || start || grant_q.size() != 0)
            @(negedge clk);
        repeat (VOICE_COUNT + 8) @(negedge clk);

        if (mismatch_count == 0 && grant_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
